### design/aiic_pkg.sv
package aiic_pkg;

    localparam int SAMPLE_W = 16;
    localparam int FRAC     = 12;
    localparam int MAX_AXES = 3;
    localparam int N_FIELDS = 10;
    localparam int REG_W    = MAX_AXES * SAMPLE_W;
    localparam int N_REGS   = 5;
    localparam int IDX_W    = 3;
    localparam int ADDR_W   = IDX_W + 3;
    localparam int PDATA_W  = 64;
    localparam int S_DATA_W = ((N_FIELDS * SAMPLE_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((MAX_AXES * SAMPLE_W + 7) / 8) * 8;

    typedef enum logic [IDX_W-1:0] {
        REG_PROP_GAINS  = 3'd0,
        REG_INTEG_GAINS = 3'd1,
        REG_RATE_GAINS  = 3'd2,
        REG_CMD_WINDOW  = 3'd3,
        REG_DRIVE_LIMIT = 3'd4
    } reg_idx_t;

    localparam logic [REG_W-1:0] CMD_WINDOW_RST  = 48'h0800_019A_019A;
    localparam logic [REG_W-1:0] DRIVE_LIMIT_RST = 48'h7FFF_7FFF_7FFF;

    typedef struct packed {
        logic [REG_W-1:0] prop_gains;
        logic [REG_W-1:0] integ_gains;
        logic [REG_W-1:0] rate_gains;
        logic [REG_W-1:0] cmd_window;
        logic [REG_W-1:0] drive_limit;
    } cfg_regs_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] kp;
        logic [SAMPLE_W-1:0] ki;
        logic [SAMPLE_W-1:0] kd;
        logic [SAMPLE_W-1:0] win;
        logic [SAMPLE_W-1:0] lim;
    } axis_cfg_t;

    typedef struct packed {
        logic ld0;
        logic ld1;
        logic ld2;
        logic ld3;
    } pipe_ctl_t;

endpackage

### design/aiic_cfg.sv
module aiic_cfg (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [aiic_pkg::ADDR_W-1:0]       paddr,
    input  logic [aiic_pkg::PDATA_W-1:0]      pwdata,
    output logic [aiic_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready,
    output aiic_pkg::cfg_regs_t               regs
);

    logic [aiic_pkg::REG_W-1:0] regs_reg [aiic_pkg::N_REGS];
    logic [aiic_pkg::IDX_W-1:0] idx;
    logic                       idx_ok;
    logic                       wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[aiic_pkg::ADDR_W-1:3];
    assign idx_ok = (idx < aiic_pkg::IDX_W'(aiic_pkg::N_REGS));
    assign wr_en  = psel && penable && pwrite && pready && idx_ok;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            regs_reg[aiic_pkg::REG_PROP_GAINS]  <= '0;
            regs_reg[aiic_pkg::REG_INTEG_GAINS] <= '0;
            regs_reg[aiic_pkg::REG_RATE_GAINS]  <= '0;
            regs_reg[aiic_pkg::REG_CMD_WINDOW]  <= aiic_pkg::CMD_WINDOW_RST;
            regs_reg[aiic_pkg::REG_DRIVE_LIMIT] <= aiic_pkg::DRIVE_LIMIT_RST;
        end else if (wr_en) begin
            regs_reg[idx] <= pwdata[aiic_pkg::REG_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (idx_ok) begin
            prdata = aiic_pkg::PDATA_W'(regs_reg[idx]);
        end
    end

    assign regs.prop_gains  = regs_reg[aiic_pkg::REG_PROP_GAINS];
    assign regs.integ_gains = regs_reg[aiic_pkg::REG_INTEG_GAINS];
    assign regs.rate_gains  = regs_reg[aiic_pkg::REG_RATE_GAINS];
    assign regs.cmd_window  = regs_reg[aiic_pkg::REG_CMD_WINDOW];
    assign regs.drive_limit = regs_reg[aiic_pkg::REG_DRIVE_LIMIT];

endmodule

### design/aiic_lane.sv
module aiic_lane #(
    parameter int INTEG_WIDTH = 32
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  aiic_pkg::pipe_ctl_t                   ctl,
    input  aiic_pkg::axis_cfg_t                   cfg,
    input  logic signed [aiic_pkg::SAMPLE_W-1:0]  angle,
    input  logic signed [aiic_pkg::SAMPLE_W-1:0]  rate,
    input  logic signed [aiic_pkg::SAMPLE_W-1:0]  target,
    input  logic        [aiic_pkg::SAMPLE_W-1:0]  period,
    output logic signed [aiic_pkg::SAMPLE_W-1:0]  drive
);

    localparam int SW     = aiic_pkg::SAMPLE_W;
    localparam int FRAC   = aiic_pkg::FRAC;
    localparam int IW     = INTEG_WIDTH;
    localparam int EW     = SW + 2;
    localparam int PM_W   = 2 * SW + 2;
    localparam int PS_W   = PM_W + 1;
    localparam int PINC_W = EW + SW + 1;
    localparam int ISH    = SW - FRAC;
    localparam int INC_W  = PINC_W - ISH;
    localparam int SUMW   = ((IW > INC_W) ? IW : INC_W) + 1;
    localparam int PIW    = IW + SW + 1;
    localparam int ACCW   = (((PS_W + FRAC) > PIW) ? (PS_W + FRAC) : PIW) + 2;
    localparam int DSH    = 2 * FRAC;

    localparam logic signed [SUMW-1:0] IMAX =
        signed'({{(SUMW-IW+1){1'b0}}, {(IW-1){1'b1}}});
    localparam logic signed [SUMW-1:0] IMIN = ~IMAX;
    localparam logic signed [ACCW-1:0] OMAX =
        signed'({{(ACCW-SW+1){1'b0}}, {(SW-1){1'b1}}});
    localparam logic signed [ACCW-1:0] OMIN = ~OMAX;
    localparam logic signed [ACCW-1:0] HALF =
        signed'(ACCW'({1'b1, {(DSH-1){1'b0}}}));
    localparam logic signed [PINC_W-1:0] IHALF =
        signed'(PINC_W'({1'b1, {(ISH-1){1'b0}}}));

    // stage 0: captured beat
    logic signed [SW-1:0]     ang_reg, rate_reg, tgt_reg;
    logic        [SW-1:0]     per_reg;
    // stage 1: products
    logic signed [PM_W-1:0]   pa_reg, pr_reg;
    logic signed [PINC_W-1:0] pinc_reg;
    // stage 2: summed terms and integral term
    logic signed [PS_W-1:0]   ps_reg;
    logic signed [PIW-1:0]    pint_reg;
    logic signed [IW-1:0]     integ_reg, integ_next;
    // stage 3: drive
    logic signed [SW-1:0]     drive_reg, drive_next;

    logic signed [EW-1:0]     ang_x, tgt_x, win_x, lo, hi, cmd, err;
    logic signed [SW:0]       nang, nrate, kp_x, kd_x, ki_x, per_x;
    logic signed [PINC_W-1:0] inc_sum;
    logic signed [INC_W-1:0]  inc;
    logic signed [SUMW-1:0]   isum;
    logic signed [ACCW-1:0]   acc, shifted, lim_x, hi_lim, lo_lim;

    always_comb begin
        ang_x = EW'(ang_reg);
        tgt_x = EW'(tgt_reg);
        win_x = signed'(EW'(cfg.win));
        lo    = ang_x - win_x;
        hi    = ang_x + win_x;
        if (tgt_x > hi) begin
            cmd = hi;
        end else if (tgt_x < lo) begin
            cmd = lo;
        end else begin
            cmd = tgt_x;
        end
        err   = cmd - ang_x;
        nang  = -((SW+1)'(ang_reg));
        nrate = -((SW+1)'(rate_reg));
        kp_x  = signed'({1'b0, cfg.kp});
        kd_x  = signed'({1'b0, cfg.kd});
        ki_x  = signed'({1'b0, cfg.ki});
        per_x = signed'({1'b0, per_reg});
    end

    always_comb begin
        inc_sum = pinc_reg + IHALF;
        inc     = INC_W'(inc_sum >>> ISH);
        isum    = SUMW'(integ_reg) + SUMW'(inc);
        if (isum > IMAX) begin
            integ_next = IW'(IMAX);
        end else if (isum < IMIN) begin
            integ_next = IW'(IMIN);
        end else begin
            integ_next = IW'(isum);
        end
    end

    always_comb begin
        acc     = (ACCW'(ps_reg) <<< FRAC) + ACCW'(pint_reg) + HALF;
        shifted = acc >>> DSH;
        lim_x   = signed'(ACCW'(cfg.lim));
        hi_lim  = (lim_x > OMAX) ? OMAX : lim_x;
        lo_lim  = (-lim_x < OMIN) ? OMIN : -lim_x;
        if (shifted > hi_lim) begin
            drive_next = SW'(hi_lim);
        end else if (shifted < lo_lim) begin
            drive_next = SW'(lo_lim);
        end else begin
            drive_next = SW'(shifted);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.ld0) begin
            ang_reg  <= angle;
            rate_reg <= rate;
            tgt_reg  <= target;
            per_reg  <= period;
        end
        if (ctl.ld1) begin
            pa_reg   <= nang * kp_x;
            pr_reg   <= nrate * kd_x;
            pinc_reg <= err * per_x;
        end
        if (ctl.ld2) begin
            ps_reg   <= PS_W'(pa_reg) + PS_W'(pr_reg);
            pint_reg <= integ_reg * ki_x;
        end
        if (ctl.ld3) begin
            drive_reg <= drive_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integ_reg <= '0;
        end else if (ctl.ld2) begin
            integ_reg <= integ_next;
        end
    end

    assign drive = drive_reg;

endmodule

### design/aiic_merge.sv
module aiic_merge (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  in_valid,
    input  logic [aiic_pkg::MAX_AXES*aiic_pkg::SAMPLE_W-1:0] drives,
    input  logic                                  m_tready,
    output logic                                  m_tvalid,
    output logic [aiic_pkg::M_DATA_W-1:0]         m_tdata,
    output logic                                  take
);

    logic                          m_tvalid_reg, m_tvalid_next;
    logic [aiic_pkg::M_DATA_W-1:0] m_tdata_reg;

    assign take = in_valid && (!m_tvalid_reg || m_tready);

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (take) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            m_tdata_reg <= aiic_pkg::M_DATA_W'(drives);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

### design/three_axis_attitude_integral_controller_top.sv
// channel   | ports                          | beat
// ----------+--------------------------------+-------------------------------------------
// input     | s_tvalid s_tready s_tdata      | angles, rates, targets (x3 each), period
// result    | m_tvalid m_tready m_tdata      | drive roll, pitch, yaw
// config    | psel penable pwrite paddr ...  | five 48-bit registers at 8*i
//
// one beat per cycle while m_tready is high; m_tvalid rises once the beat passes stage 3
// one lane per axis, four stages each; the integral loop closes in stage 2
// stalls on m_tready back up stage by stage, empty stages keep taking beats
// synchronous reset clears integrals, valid bits and registers to defaults
module three_axis_attitude_integral_controller_top #(
    parameter int AXES        = 3,
    parameter int INTEG_WIDTH = 32
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // angle_roll, angle_pitch, angle_yaw, rate_roll, rate_pitch, rate_yaw,
    // target_roll, target_pitch, target_yaw, period
    input  logic [aiic_pkg::S_DATA_W-1:0]      s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // drive_roll, drive_pitch, drive_yaw
    output logic [aiic_pkg::M_DATA_W-1:0]      m_tdata,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [aiic_pkg::ADDR_W-1:0]        paddr,
    input  logic [aiic_pkg::PDATA_W-1:0]       pwdata,
    output logic [aiic_pkg::PDATA_W-1:0]       prdata,
    output logic                               pready
);

    localparam int SW = aiic_pkg::SAMPLE_W;
    localparam int NA = aiic_pkg::MAX_AXES;

    aiic_pkg::cfg_regs_t regs;
    aiic_pkg::pipe_ctl_t ctl;

    logic v0_reg, v1_reg, v2_reg, v3_reg;
    logic v0_next, v1_next, v2_next, v3_next;
    logic rdy1, rdy2, rdy3, take;
    logic [NA*SW-1:0] drives;

    aiic_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .regs    (regs)
    );

    assign rdy3     = !v3_reg || take;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = !v0_reg || rdy1;

    assign ctl.ld0 = s_tvalid && s_tready;
    assign ctl.ld1 = v0_reg && rdy1;
    assign ctl.ld2 = v1_reg && rdy2;
    assign ctl.ld3 = v2_reg && rdy3;

    always_comb begin
        v0_next = ctl.ld0 || (v0_reg && !ctl.ld1);
        v1_next = ctl.ld1 || (v1_reg && !ctl.ld2);
        v2_next = ctl.ld2 || (v2_reg && !ctl.ld3);
        v3_next = ctl.ld3 || (v3_reg && !take);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v0_reg <= v0_next;
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    for (genvar a = 0; a < NA; a++) begin : g_lane
        if (a < AXES) begin : g_on
            aiic_pkg::axis_cfg_t acfg;

            assign acfg.kp  = regs.prop_gains[a*SW +: SW];
            assign acfg.ki  = regs.integ_gains[a*SW +: SW];
            assign acfg.kd  = regs.rate_gains[a*SW +: SW];
            assign acfg.win = regs.cmd_window[a*SW +: SW];
            assign acfg.lim = regs.drive_limit[a*SW +: SW];

            aiic_lane #(
                .INTEG_WIDTH (INTEG_WIDTH)
            ) u_lane (
                .aclk    (aclk),
                .aresetn (aresetn),
                .ctl     (ctl),
                .cfg     (acfg),
                .angle   (signed'(s_tdata[a*SW +: SW])),
                .rate    (signed'(s_tdata[(NA+a)*SW +: SW])),
                .target  (signed'(s_tdata[(2*NA+a)*SW +: SW])),
                .period  (s_tdata[3*NA*SW +: SW]),
                .drive   (drives[a*SW +: SW])
            );
        end else begin : g_off
            assign drives[a*SW +: SW] = '0;
        end
    end

    aiic_merge u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (v3_reg),
        .drives   (drives),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .take     (take)
    );

endmodule
